>>> sv/ehc_pkg.sv
// ----------------------------------------------------------------------------
// ehc_pkg
// Shared types and constants for the Ethernet/IPv4 header classifier.
// ----------------------------------------------------------------------------
package ehc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned LEN_W   = COUNT_W + 1;
    localparam int unsigned MAC_W   = 48;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 7'd127;
    localparam logic [LEN_W-1:0]   ETH_HDR_BYTES = 8'd14;
    localparam logic [LEN_W-1:0]   IP_HDR_END    = 8'd34;
    localparam logic [LEN_W-1:0]   TCP_NEED      = 8'd14;
    localparam logic [LEN_W-1:0]   UDP_NEED      = 8'd4;

    // Frame offsets
    localparam logic [COUNT_W-1:0] POS_ETYPE_HI = 7'd12;
    localparam logic [COUNT_W-1:0] POS_ETYPE_LO = 7'd13;
    localparam logic [COUNT_W-1:0] POS_VER_IHL  = 7'd14;
    localparam logic [COUNT_W-1:0] POS_LEN_HI   = 7'd16;
    localparam logic [COUNT_W-1:0] POS_LEN_LO   = 7'd17;
    localparam logic [COUNT_W-1:0] POS_PROTO    = 7'd23;
    localparam logic [COUNT_W-1:0] POS_SA_FIRST = 7'd26;
    localparam logic [COUNT_W-1:0] POS_DA_FIRST = 7'd30;
    localparam logic [COUNT_W-1:0] POS_DA_END   = 7'd34;

    // Offsets inside the L4 header
    localparam logic [COUNT_W-1:0] L4_SP_HI = 7'd0;
    localparam logic [COUNT_W-1:0] L4_SP_LO = 7'd1;
    localparam logic [COUNT_W-1:0] L4_DP_HI = 7'd2;
    localparam logic [COUNT_W-1:0] L4_DP_LO = 7'd3;
    localparam logic [COUNT_W-1:0] L4_FLAGS = 7'd13;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_GRE  = 8'd47;
    localparam logic [7:0] PROTO_ESP  = 8'd50;
    localparam logic [7:0] PROTO_AH   = 8'd51;

    localparam int unsigned FLAG_FIN_BIT = 0;
    localparam int unsigned FLAG_SYN_BIT = 1;
    localparam int unsigned FLAG_ACK_BIT = 4;

    localparam logic [1:0] STATUS_SHORT     = 2'd0;
    localparam logic [1:0] STATUS_OK        = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [1:0] DIR_NONE    = 2'd0;
    localparam logic [1:0] DIR_TO_GW   = 2'd1;
    localparam logic [1:0] DIR_FROM_GW = 2'd2;

    localparam logic [2:0] CLASS_OTHER = 3'd0;
    localparam logic [2:0] CLASS_TCP   = 3'd1;
    localparam logic [2:0] CLASS_UDP   = 3'd2;
    localparam logic [2:0] CLASS_ICMP  = 3'd3;
    localparam logic [2:0] CLASS_VPN   = 3'd4;

    localparam logic [1:0] EVENT_NONE  = 2'd0;
    localparam logic [1:0] EVENT_OPEN  = 2'd1;
    localparam logic [1:0] EVENT_CLOSE = 2'd2;

    // Header fields captured so far in the current frame
    typedef struct packed {
        logic        dest_gw;
        logic        src_gw;
        logic [15:0] etype;
        logic [3:0]  hwords;
        logic [7:0]  proto;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] tlen;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  flags;
    } frame_t;

    localparam frame_t FRAME_CLEAR = '{
        dest_gw: 1'b1, src_gw: 1'b1, etype: '0, hwords: '0, proto: '0,
        saddr: '0, daddr: '0, tlen: '0, sport: '0, dport: '0, flags: '0
    };

    typedef struct packed {
        logic [1:0]  header_status;
        logic [15:0] ether_type;
        logic [1:0]  direction;
        logic [7:0]  ipv4_proto;
        logic [2:0]  protocol_class;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] total_length;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  flag_bits;
        logic [1:0]  log_event;
    } result_t;

endpackage

>>> sv/ehc_capture.sv
// ----------------------------------------------------------------------------
// ehc_capture
// Per-frame byte counter and header field capture.
// ----------------------------------------------------------------------------
module ehc_capture (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    input  logic [47:0]             gw_mac,
    output ehc_pkg::frame_t         frame_upd,
    output logic [ehc_pkg::LEN_W-1:0] frame_len
);
    import ehc_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    frame_t             frame_reg;
    frame_t             frame_next;

    logic [COUNT_W-1:0] pos;
    logic [2:0]         mac_idx;
    logic [7:0]         gw_byte;
    logic [3:0]         ihl;
    logic [COUNT_W-1:0] l4_base;
    logic [COUNT_W-1:0] l4_off;

    assign pos       = count_reg;
    assign frame_len = {1'b0, pos} + LEN_W'(1);
    assign mac_idx   = (pos < 7'd6) ? pos[2:0] : 3'(pos - 7'd6);

    always_comb
    begin
        case (mac_idx)
            3'd0:    gw_byte = gw_mac[47:40];
            3'd1:    gw_byte = gw_mac[39:32];
            3'd2:    gw_byte = gw_mac[31:24];
            3'd3:    gw_byte = gw_mac[23:16];
            3'd4:    gw_byte = gw_mac[15:8];
            3'd5:    gw_byte = gw_mac[7:0];
            default: gw_byte = gw_mac[7:0];
        endcase
    end

    // IHL of the current byte counts when this is the version/IHL byte
    assign ihl     = (pos == POS_VER_IHL) ? data_byte[3:0] : frame_reg.hwords;
    assign l4_base = ETH_HDR_BYTES[COUNT_W-1:0] + {1'b0, ihl, 2'b00};
    assign l4_off  = pos - l4_base;

    always_comb
    begin
        frame_upd = frame_reg;
        if (pos < COUNT_MAX)
        begin
            if (pos < 7'd6)
            begin
                if (data_byte != gw_byte)
                    frame_upd.dest_gw = 1'b0;
            end
            else if (pos < POS_ETYPE_HI)
            begin
                if (data_byte != gw_byte)
                    frame_upd.src_gw = 1'b0;
            end
            else if (pos == POS_ETYPE_HI)
                frame_upd.etype[15:8] = data_byte;
            else if (pos == POS_ETYPE_LO)
                frame_upd.etype[7:0] = data_byte;
            else if (pos == POS_VER_IHL)
                frame_upd.hwords = data_byte[3:0];
            else if (pos == POS_LEN_HI)
                frame_upd.tlen[15:8] = data_byte;
            else if (pos == POS_LEN_LO)
                frame_upd.tlen[7:0] = data_byte;
            else if (pos == POS_PROTO)
                frame_upd.proto = data_byte;
            else if (pos >= POS_SA_FIRST && pos < POS_DA_FIRST)
                frame_upd.saddr = {frame_reg.saddr[23:0], data_byte};
            else if (pos >= POS_DA_FIRST && pos < POS_DA_END)
                frame_upd.daddr = {frame_reg.daddr[23:0], data_byte};

            if (pos >= l4_base)
            begin
                if (l4_off == L4_SP_HI)
                    frame_upd.sport[15:8] = data_byte;
                else if (l4_off == L4_SP_LO)
                    frame_upd.sport[7:0] = data_byte;
                else if (l4_off == L4_DP_HI)
                    frame_upd.dport[15:8] = data_byte;
                else if (l4_off == L4_DP_LO)
                    frame_upd.dport[7:0] = data_byte;
                else if (l4_off == L4_FLAGS)
                    frame_upd.flags = data_byte;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        frame_next = frame_reg;
        if (en)
        begin
            if (last_byte)
            begin
                count_next = '0;
                frame_next = FRAME_CLEAR;
            end
            else
            begin
                frame_next = frame_upd;
                if (count_reg < COUNT_MAX)
                    count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            frame_reg <= FRAME_CLEAR;
        end
        else
        begin
            count_reg <= count_next;
            frame_reg <= frame_next;
        end
    end

endmodule

>>> sv/ehc_classify.sv
// ----------------------------------------------------------------------------
// ehc_classify
// Builds the result of a frame from its captured fields and length.
// ----------------------------------------------------------------------------
module ehc_classify (
    input  ehc_pkg::frame_t           frame,
    input  logic [ehc_pkg::LEN_W-1:0] frame_len,
    output ehc_pkg::result_t          result
);
    import ehc_pkg::*;

    logic [LEN_W-1:0] l4_start;
    logic [2:0]       cls;

    assign l4_start = ETH_HDR_BYTES + {2'b00, frame.hwords, 2'b00};

    always_comb
    begin
        if (frame.proto == PROTO_TCP)
            cls = CLASS_TCP;
        else if (frame.proto == PROTO_UDP)
            cls = CLASS_UDP;
        else if (frame.proto == PROTO_ICMP)
            cls = CLASS_ICMP;
        else if (frame.proto == PROTO_GRE || frame.proto == PROTO_ESP ||
                 frame.proto == PROTO_AH)
            cls = CLASS_VPN;
        else
            cls = CLASS_OTHER;
    end

    always_comb
    begin
        result = '0;
        result.header_status = STATUS_OK;
        if (frame_len < ETH_HDR_BYTES)
            result.header_status = STATUS_SHORT;
        else
        begin
            result.ether_type = frame.etype;
            if (frame.dest_gw)
                result.direction = DIR_TO_GW;
            else if (frame.src_gw)
                result.direction = DIR_FROM_GW;
            else
                result.direction = DIR_NONE;

            if (frame.etype == ETHERTYPE_IPV4)
            begin
                if (frame_len < IP_HDR_END)
                    result.header_status = STATUS_TRUNCATED;
                else
                begin
                    result.ipv4_proto          = frame.proto;
                    result.protocol_class      = cls;
                    result.source_address      = frame.saddr;
                    result.destination_address = frame.daddr;
                    result.total_length        = frame.tlen;
                    if (cls == CLASS_TCP)
                    begin
                        if (frame_len < l4_start + TCP_NEED)
                            result.header_status = STATUS_TRUNCATED;
                        else
                        begin
                            result.source_port      = frame.sport;
                            result.destination_port = frame.dport;
                            result.flag_bits        = frame.flags;
                            if (frame.flags[FLAG_SYN_BIT] && frame.flags[FLAG_ACK_BIT])
                                result.log_event = EVENT_OPEN;
                            else if (frame.flags[FLAG_FIN_BIT])
                                result.log_event = EVENT_CLOSE;
                            else
                                result.log_event = EVENT_NONE;
                        end
                    end
                    else if (cls == CLASS_UDP)
                    begin
                        if (frame_len < l4_start + UDP_NEED)
                            result.header_status = STATUS_TRUNCATED;
                        else
                        begin
                            result.source_port      = frame.sport;
                            result.destination_port = frame.dport;
                        end
                    end
                end
            end
        end
    end

endmodule

>>> sv/ethernet_ipv4_header_classifier_unit.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_classifier_unit
// Classifies an Ethernet frame fed one byte per item; one result per frame.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                   | Moves
//  ---------+-------------------------------------------+---------------------
//  in       | in_valid / in_ready, data_byte, last_byte | one frame byte
//  out      | out_valid / out_ready, 12 result fields   | one frame result
//  cfg      | cfg_write_en, cfg_write_data              | gateway MAC write
//
//  One item per cycle sustained while no last byte is stalled. An accepted byte
//  is held in the input register, where the capture and classify logic evaluate
//  it; a last byte's result lands in the output register as the byte leaves.
//  The input register only stalls for a last byte while the output register
//  still holds an untaken result; other bytes always move on.
//  rst_n clears the byte counter, the frame state, the gateway MAC and both
//  valid flags.
//
module ethernet_ipv4_header_classifier_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write_en,
    input  logic [47:0] cfg_write_data,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  header_status,
    output logic [15:0] ether_type,
    output logic [1:0]  direction,
    output logic [7:0]  ipv4_proto,
    output logic [2:0]  protocol_class,
    output logic [31:0] source_address,
    output logic [31:0] destination_address,
    output logic [15:0] total_length,
    output logic [15:0] source_port,
    output logic [15:0] destination_port,
    output logic [7:0]  flag_bits,
    output logic [1:0]  log_event
);
    import ehc_pkg::*;

    logic [47:0]      gw_mac_reg;

    // input register
    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;

    // output register
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          result_reg;

    frame_t           frame_upd;
    logic [LEN_W-1:0] frame_len;
    result_t          result;
    logic             advance;

    // A plain byte never needs output space; a last byte needs a free slot
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gw_mac_reg <= '0;
        else if (cfg_write_en)
            gw_mac_reg <= cfg_write_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    ehc_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .data_byte   (byte_reg),
        .last_byte   (last_reg),
        .gw_mac      (gw_mac_reg),
        .frame_upd   (frame_upd),
        .frame_len   (frame_len)
    );

    ehc_classify u_classify (
        .frame     (frame_upd),
        .frame_len (frame_len),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && last_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
            result_reg <= result;
    end

    assign out_valid           = out_valid_reg;
    assign header_status       = result_reg.header_status;
    assign ether_type          = result_reg.ether_type;
    assign direction           = result_reg.direction;
    assign ipv4_proto          = result_reg.ipv4_proto;
    assign protocol_class      = result_reg.protocol_class;
    assign source_address      = result_reg.source_address;
    assign destination_address = result_reg.destination_address;
    assign total_length        = result_reg.total_length;
    assign source_port         = result_reg.source_port;
    assign destination_port    = result_reg.destination_port;
    assign flag_bits           = result_reg.flag_bits;
    assign log_event           = result_reg.log_event;

endmodule

>>> sv/ehc_checker.sv
// ----------------------------------------------------------------------------
// ehc_checker
// Port-level checks for the header classifier, bound to the top level.
// ----------------------------------------------------------------------------
module ehc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  header_status,
    input logic [15:0] ether_type,
    input logic [1:0]  direction,
    input logic [7:0]  ipv4_proto,
    input logic [2:0]  protocol_class,
    input logic [15:0] source_port,
    input logic [15:0] destination_port,
    input logic [7:0]  flag_bits,
    input logic [1:0]  log_event
);
    import ehc_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(header_status) &&
        $stable(ether_type) && $stable(source_port) && $stable(log_event))
        else $error("result changed while stalled");

    // Short frame carries nothing but its status
    a_short_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_status == STATUS_SHORT |->
        ether_type == '0 && direction == DIR_NONE && ipv4_proto == '0 &&
        protocol_class == CLASS_OTHER)
        else $error("short frame result has fields set");

    // A protocol class only comes from an IPv4 frame
    a_class_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && protocol_class != CLASS_OTHER |->
        ether_type == ETHERTYPE_IPV4 && ipv4_proto != '0)
        else $error("protocol class without IPv4");

    // Flags and log events only for TCP; ports only for TCP or UDP
    a_l4_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && protocol_class != CLASS_TCP |->
        flag_bits == '0 && log_event == EVENT_NONE &&
        (protocol_class == CLASS_UDP || (source_port == '0 && destination_port == '0)))
        else $error("L4 fields set for wrong protocol");

endmodule

bind ethernet_ipv4_header_classifier_unit ehc_checker u_ehc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .header_status    (header_status),
    .ether_type       (ether_type),
    .direction        (direction),
    .ipv4_proto       (ipv4_proto),
    .protocol_class   (protocol_class),
    .source_port      (source_port),
    .destination_port (destination_port),
    .flag_bits        (flag_bits),
    .log_event        (log_event)
);

>>> tb/ehc_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_frame_checker
// Watches the byte, result and gateway-write ports of the header classifier.
// Keeps its own copy of the per-frame capture state, predicts the result of
// each frame when its last byte is taken, and compares every result taken
// from the block field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ehc_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [47:0] cfg_write_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  header_status,
    input  logic [15:0] ether_type,
    input  logic [1:0]  direction,
    input  logic [7:0]  ipv4_proto,
    input  logic [2:0]  protocol_class,
    input  logic [31:0] source_address,
    input  logic [31:0] destination_address,
    input  logic [15:0] total_length,
    input  logic [15:0] source_port,
    input  logic [15:0] destination_port,
    input  logic [7:0]  flag_bits,
    input  logic [1:0]  log_event,
    output int unsigned mismatches,
    output int unsigned results_matched
);
    import ehc_pkg::*;

    localparam int MAC_BYTES = 6;

    logic [47:0]        gw_copy  = '0;
    logic [COUNT_W-1:0] byte_pos = '0;
    frame_t             hdr      = FRAME_CLEAR;
    result_t            predicted_frames[$];
    int unsigned        err_total  = 0;
    int unsigned        seen_total = 0;

    function automatic logic [7:0] gw_octet(input int idx);
        return gw_copy[8*(5-idx) +: 8];
    endfunction

    // Capture one frame byte; on the last byte queue the frame's classification.
    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        int      pos;
        int      flen;
        int      l4_pos;
        result_t r;
        pos = byte_pos;
        if (byte_pos != COUNT_MAX) begin
            if (pos < MAC_BYTES)
            begin
                if (b != gw_octet(pos)) hdr.dest_gw = 1'b0;
            end
            else if (pos < 2 * MAC_BYTES)
            begin
                if (b != gw_octet(pos - MAC_BYTES)) hdr.src_gw = 1'b0;
            end
            else if (pos == POS_ETYPE_HI) hdr.etype[15:8] = b;
            else if (pos == POS_ETYPE_LO) hdr.etype[7:0] = b;
            else if (pos == POS_VER_IHL) hdr.hwords = b[3:0];
            else if (pos == POS_LEN_HI) hdr.tlen[15:8] = b;
            else if (pos == POS_LEN_LO) hdr.tlen[7:0] = b;
            else if (pos == POS_PROTO) hdr.proto = b;
            else if (pos >= POS_SA_FIRST && pos < POS_DA_FIRST)
                hdr.saddr = {hdr.saddr[23:0], b};
            else if (pos >= POS_DA_FIRST && pos < POS_DA_END)
                hdr.daddr = {hdr.daddr[23:0], b};
            // L4 offset follows the IHL just captured when this is byte 14
            l4_pos = ETH_HDR_BYTES + 4 * hdr.hwords;
            if (pos >= l4_pos) begin
                case (pos - l4_pos)
                    L4_SP_HI: hdr.sport[15:8] = b;
                    L4_SP_LO: hdr.sport[7:0]  = b;
                    L4_DP_HI: hdr.dport[15:8] = b;
                    L4_DP_LO: hdr.dport[7:0]  = b;
                    L4_FLAGS: hdr.flags       = b;
                    default: ;
                endcase
            end
            byte_pos = byte_pos + 1'b1;
        end
        if (fin) begin
            flen = pos + 1;
            r = '0;
            r.header_status = STATUS_OK;
            if (flen < ETH_HDR_BYTES) begin
                r.header_status = STATUS_SHORT;
            end
            else begin
                r.ether_type = hdr.etype;
                r.direction  = hdr.dest_gw ? DIR_TO_GW : (hdr.src_gw ? DIR_FROM_GW : DIR_NONE);
                if (hdr.etype == ETHERTYPE_IPV4) begin
                    if (flen < IP_HDR_END) begin
                        r.header_status = STATUS_TRUNCATED;
                    end
                    else begin
                        l4_pos = ETH_HDR_BYTES + 4 * hdr.hwords;
                        r.ipv4_proto          = hdr.proto;
                        r.source_address      = hdr.saddr;
                        r.destination_address = hdr.daddr;
                        r.total_length        = hdr.tlen;
                        case (hdr.proto)
                            PROTO_TCP:                     r.protocol_class = CLASS_TCP;
                            PROTO_UDP:                     r.protocol_class = CLASS_UDP;
                            PROTO_ICMP:                    r.protocol_class = CLASS_ICMP;
                            PROTO_GRE, PROTO_ESP, PROTO_AH: r.protocol_class = CLASS_VPN;
                            default:                       r.protocol_class = CLASS_OTHER;
                        endcase
                        if (r.protocol_class == CLASS_TCP) begin
                            if (flen < l4_pos + TCP_NEED) begin
                                r.header_status = STATUS_TRUNCATED;
                            end
                            else begin
                                r.source_port      = hdr.sport;
                                r.destination_port = hdr.dport;
                                r.flag_bits        = hdr.flags;
                                if (hdr.flags[FLAG_SYN_BIT] && hdr.flags[FLAG_ACK_BIT])
                                    r.log_event = EVENT_OPEN;
                                else if (hdr.flags[FLAG_FIN_BIT])
                                    r.log_event = EVENT_CLOSE;
                                else
                                    r.log_event = EVENT_NONE;
                            end
                        end
                        else if (r.protocol_class == CLASS_UDP) begin
                            if (flen < l4_pos + UDP_NEED) begin
                                r.header_status = STATUS_TRUNCATED;
                            end
                            else begin
                                r.source_port      = hdr.sport;
                                r.destination_port = hdr.dport;
                            end
                        end
                    end
                end
            end
            predicted_frames.push_back(r);
            hdr      = FRAME_CLEAR;
            byte_pos = '0;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            err_total++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            gw_copy  = '0;
            byte_pos = '0;
            hdr      = FRAME_CLEAR;
            predicted_frames.delete();
            err_total  = 0;
            seen_total = 0;
            mismatches      <= 0;
            results_matched <= 0;
        end
        else begin
            // results first: a frame finishing at this edge cannot be out yet
            if (out_valid && out_ready) begin
                if (predicted_frames.size() == 0) begin
                    err_total++;
                    $display("%0t: result with no frame pending, expected none, actual status %0h",
                             $time, header_status);
                end
                else begin
                    want = predicted_frames.pop_front();
                    compare_field("header_status",       want.header_status,       header_status);
                    compare_field("ether_type",          want.ether_type,          ether_type);
                    compare_field("direction",           want.direction,           direction);
                    compare_field("ipv4_proto",          want.ipv4_proto,          ipv4_proto);
                    compare_field("protocol_class",      want.protocol_class,      protocol_class);
                    compare_field("source_address",      want.source_address,      source_address);
                    compare_field("destination_address", want.destination_address,
                                  destination_address);
                    compare_field("total_length",        want.total_length,        total_length);
                    compare_field("source_port",         want.source_port,         source_port);
                    compare_field("destination_port",    want.destination_port,    destination_port);
                    compare_field("flag_bits",           want.flag_bits,           flag_bits);
                    compare_field("log_event",           want.log_event,           log_event);
                    seen_total++;
                end
            end
            if (in_valid && in_ready) absorb_byte(data_byte, last_byte);
            if (cfg_write_en) gw_copy = cfg_write_data;
            mismatches      <= err_total;
            results_matched <= seen_total;
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives Ethernet frames byte by byte into the header classifier: a directed
// set of corner frames, then random frames under several idle and stall
// mixes and one long output hold-off. A separate checker predicts and
// compares every result; this module only makes stimulus and gives verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import ehc_pkg::*;

    // MAC selection for generated frames
    localparam int MAC_RANDOM  = 0;
    localparam int MAC_GATEWAY = 1;
    localparam int MAC_NEAR    = 2;   // gateway with one byte changed

    localparam int PHASE_BYTES = 220;  // random bytes per idle phase
    localparam int HOLD_CYCLES = 300;  // receiver hold-off length
    localparam int DRAIN_WAIT  = 4;    // extra wait after the last result is back

    localparam logic [7:0] FL_FIN = 8'd1 << FLAG_FIN_BIT;
    localparam logic [7:0] FL_SYN = 8'd1 << FLAG_SYN_BIT;
    localparam logic [7:0] FL_ACK = 8'd1 << FLAG_ACK_BIT;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [47:0] cfg_write_data = '0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte      = '0;
    logic        last_byte      = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b1;
    logic [1:0]  header_status;
    logic [15:0] ether_type;
    logic [1:0]  direction;
    logic [7:0]  ipv4_proto;
    logic [2:0]  protocol_class;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] total_length;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  flag_bits;
    logic [1:0]  log_event;

    int unsigned mismatches;
    int unsigned results_matched;

    // Stimulus bookkeeping
    logic [47:0] gw_now       = '0;   // gateway MAC currently in the block
    logic [7:0]  frame_buf[$];
    int unsigned bytes_sent   = 0;
    int unsigned frames_sent  = 0;
    int unsigned gw_settings  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_asks     = 0;
    int unsigned hold_served   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ethernet_ipv4_header_classifier_unit u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_en        (cfg_write_en),
        .cfg_write_data      (cfg_write_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_byte           (data_byte),
        .last_byte           (last_byte),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .header_status       (header_status),
        .ether_type          (ether_type),
        .direction           (direction),
        .ipv4_proto          (ipv4_proto),
        .protocol_class      (protocol_class),
        .source_address      (source_address),
        .destination_address (destination_address),
        .total_length        (total_length),
        .source_port         (source_port),
        .destination_port    (destination_port),
        .flag_bits           (flag_bits),
        .log_event           (log_event)
    );

    ehc_frame_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_en        (cfg_write_en),
        .cfg_write_data      (cfg_write_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_byte           (data_byte),
        .last_byte           (last_byte),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .header_status       (header_status),
        .ether_type          (ether_type),
        .direction           (direction),
        .ipv4_proto          (ipv4_proto),
        .protocol_class      (protocol_class),
        .source_address      (source_address),
        .destination_address (destination_address),
        .total_length        (total_length),
        .source_port         (source_port),
        .destination_port    (destination_port),
        .flag_bits           (flag_bits),
        .log_event           (log_event),
        .mismatches          (mismatches),
        .results_matched     (results_matched)
    );

    // ------------------------------------------------------------------------
    // Result side. out_ready is redrawn every cycle from stall_pct. When the
    // stimulus asks for a hold-off (hold_asks moves), ready is held low until a
    // countdown here, loaded from HOLD_CYCLES, runs out, so the block backs up into its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_served != hold_asks) begin
                hold_served = hold_asks;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Timeout: stimulus or results stuck");
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Byte sender. Optional idle cycles first (valid low), then the byte is
    // held until in_ready is seen high at a rising edge. Valid is left high
    // on return so back-to-back bytes keep it up without a dip.
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
        if (fin) frames_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) push_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Stop offering bytes and wait until every frame sent has its result
    // back, plus the block's latency so nothing is still in flight.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (results_matched < frames_sent) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Only called with the block drained.
    task automatic set_gateway(input logic [47:0] mac);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= mac;
        gw_now = mac;
        gw_settings++;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [47:0] pick_mac(input int sel);
        logic [47:0] mac;
        int          k;
        mac = gw_now;
        if (sel == MAC_RANDOM) begin
            mac = {16'($urandom()), 32'($urandom())};
        end
        else if (sel == MAC_NEAR) begin
            k = $urandom_range(5);
            mac[8*k +: 8] = mac[8*k +: 8] ^ 8'($urandom_range(1, 255));
        end
        return mac;
    endfunction

    // Length of a frame that just holds the full L4 header of its protocol
    function automatic int full_length(input logic [7:0] ver_ihl, input logic [7:0] proto);
        int l4_pos;
        l4_pos = 14 + 4 * ver_ihl[3:0];
        if (proto == PROTO_TCP) return l4_pos + 20;
        if (proto == PROTO_UDP) return l4_pos + 8;
        return (l4_pos > 34) ? l4_pos : 34;
    endfunction

    // Fill frame_buf with frame_len bytes. Header fields land at their
    // offsets; the TCP flags byte goes to 14 + IHL*4 + 13 unless a fixed
    // header byte owns that offset (small IHL overlaps the IP header).
    task automatic build_frame(input int dst_sel, input int src_sel, input logic [15:0] etype,
                               input logic [7:0] ver_ihl, input logic [7:0] proto,
                               input logic [7:0] tcp_flags, input int frame_len);
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        int          flag_pos;
        dst_mac  = pick_mac(dst_sel);
        src_mac  = pick_mac(src_sel);
        flag_pos = 14 + 4 * ver_ihl[3:0] + 13;
        frame_buf.delete();
        for (int p = 0; p < frame_len; p++) begin
            if (p < 6)                 frame_buf.push_back(dst_mac[8*(5-p) +: 8]);
            else if (p < 12)           frame_buf.push_back(src_mac[8*(11-p) +: 8]);
            else if (p == POS_ETYPE_HI) frame_buf.push_back(etype[15:8]);
            else if (p == POS_ETYPE_LO) frame_buf.push_back(etype[7:0]);
            else if (p == POS_VER_IHL)  frame_buf.push_back(ver_ihl);
            else if (p == POS_PROTO)    frame_buf.push_back(proto);
            else if (p == flag_pos)     frame_buf.push_back(tcp_flags);
            else                        frame_buf.push_back(8'($urandom()));
        end
    endtask

    // Mostly well-formed IPv4 frames with random content; some short, cut,
    // over-long, odd IHL or non-IPv4 frames mixed in.
    task automatic send_random_frame();
        logic [15:0] et;
        logic [7:0]  vi;
        logic [7:0]  pr;
        logic [7:0]  fl;
        int          full;
        int          sel;
        int          flen;
        et = ($urandom_range(99) < 80) ? ETHERTYPE_IPV4 : 16'($urandom());
        vi = ($urandom_range(99) < 75) ? 8'h45 : 8'($urandom());
        case ($urandom_range(9))
            0, 1, 2: pr = PROTO_TCP;
            3, 4:    pr = PROTO_UDP;
            5:       pr = PROTO_ICMP;
            6:       pr = PROTO_GRE;
            7:       pr = PROTO_ESP;
            8:       pr = PROTO_AH;
            default: pr = 8'($urandom());
        endcase
        case ($urandom_range(5))
            0:       fl = FL_SYN | FL_ACK;
            1:       fl = FL_FIN;
            2:       fl = FL_FIN | FL_ACK;
            default: fl = 8'($urandom());
        endcase
        full = full_length(vi, pr);
        sel  = $urandom_range(99);
        if (sel < 10)      flen = $urandom_range(1, 13);
        else if (sel < 25) flen = $urandom_range(14, full);
        else if (sel < 29) flen = $urandom_range(128, 180);
        else               flen = full + $urandom_range(0, 12);
        build_frame($urandom_range(2), $urandom_range(2), et, vi, pr, fl, flen);
        send_frame();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase_start;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed frames, no idling ----
        set_gateway(48'h0200_5E10_2030);
        // short frames: a single byte and one byte short of the Ethernet header
        build_frame(MAC_GATEWAY, MAC_GATEWAY, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'hFF, 1);
        send_frame();
        build_frame(MAC_GATEWAY, MAC_RANDOM, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00, 13);
        send_frame();
        // bare Ethernet header, not IPv4, both MACs match: destination wins
        build_frame(MAC_GATEWAY, MAC_GATEWAY, 16'h86DD, 8'h60, 8'h00, 8'h00, 14);
        send_frame();
        // IPv4 header cut one byte short; source is the gateway
        build_frame(MAC_RANDOM, MAC_GATEWAY, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00, 33);
        send_frame();
        // exact IPv4 header, ICMP, neither MAC matches
        build_frame(MAC_RANDOM, MAC_NEAR, ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 8'h00, 34);
        send_frame();
        // TCP open, full header; then TCP close cut inside the L4 header
        build_frame(MAC_NEAR, MAC_GATEWAY, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
                    FL_SYN | FL_ACK, 54);
        send_frame();
        build_frame(MAC_RANDOM, MAC_RANDOM, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, FL_FIN, 53);
        send_frame();
        build_frame(MAC_RANDOM, MAC_RANDOM, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
                    FL_FIN | FL_ACK, 60);
        send_frame();
        // UDP with exactly the ports, and UDP one byte short of them
        build_frame(MAC_GATEWAY, MAC_RANDOM, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00, 38);
        send_frame();
        build_frame(MAC_GATEWAY, MAC_RANDOM, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00, 37);
        send_frame();
        // VPN protocols and an unknown one
        build_frame(MAC_RANDOM, MAC_RANDOM, ETHERTYPE_IPV4, 8'h45, PROTO_GRE, 8'h00, 40);
        send_frame();
        build_frame(MAC_RANDOM, MAC_RANDOM, ETHERTYPE_IPV4, 8'h45, PROTO_ESP, 8'h00, 40);
        send_frame();
        build_frame(MAC_RANDOM, MAC_RANDOM, ETHERTYPE_IPV4, 8'h45, PROTO_AH, 8'h00, 40);
        send_frame();
        build_frame(MAC_RANDOM, MAC_RANDOM, ETHERTYPE_IPV4, 8'h45, 8'hFF, 8'h00, 40);
        send_frame();
        // IHL of zero: L4 header sits on top of the IP header
        build_frame(MAC_RANDOM, MAC_RANDOM, ETHERTYPE_IPV4, 8'h40, PROTO_TCP,
                    FL_SYN | FL_ACK, 34);
        send_frame();
        // IHL of 15 in a frame past counter saturation
        build_frame(MAC_RANDOM, MAC_RANDOM, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, FL_FIN, 150);
        send_frame();
        wait_results_drained();

        // gateway extremes: all ones, then all zeros
        set_gateway(48'hFFFF_FFFF_FFFF);
        build_frame(MAC_GATEWAY, MAC_GATEWAY, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 60);
        send_frame();
        wait_results_drained();
        set_gateway(48'h0000_0000_0000);
        build_frame(MAC_NEAR, MAC_GATEWAY, 16'h0000, 8'h00, 8'h00, 8'h00, 20);
        send_frame();
        wait_results_drained();

        // ---- random frames across idle mixes, new gateway per phase ----
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            case (ph)
                0: set_gateway({16'($urandom()), 32'($urandom())});
                1: set_gateway(48'hFFFF_FFFF_FFFF);
                2: set_gateway(48'h0000_0000_0000);
                default: set_gateway({16'($urandom()), 32'($urandom())});
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) send_random_frame();
            // sender pauses here until every result is back
            wait_results_drained();
        end

        // ---- back-pressure: receiver holds off while short frames pile up ----
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_asks    <= hold_asks + 1;
        repeat (10) begin
            build_frame(MAC_RANDOM, MAC_GATEWAY, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00,
                        $urandom_range(1, 16));
            send_frame();
        end
        wait_results_drained();

        repeat (8) @(posedge clk);
        $display("Covered %0d frames (%0d bytes) over %0d gateway settings, %0d results checked.",
                 frames_sent, bytes_sent, gw_settings, results_matched);
        $display("Phases: directed corners, four idle/stall mixes, one %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && results_matched == frames_sent)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
